// ----- sv/fbst_pkg.sv -----
// shared types and constants for the focus/break session timer
// no dependencies; imported by every module of the block
package fbst_pkg;

  // timer phase, also reported on the result word
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_FOCUS    = 4'd1,
    PH_PAUSED   = 4'd2,
    PH_SHORT    = 4'd3,
    PH_LONG     = 4'd4,
    PH_BPAUSED  = 4'd5,
    PH_REFLECT  = 4'd6,
    PH_COMPLETE = 4'd7,
    PH_ABANDON  = 4'd8
  } phase_t;

  // event codes carried on the input word
  localparam logic [3:0] EV_START   = 4'd0;
  localparam logic [3:0] EV_PAUSE   = 4'd1;
  localparam logic [3:0] EV_TICK    = 4'd2;
  localparam logic [3:0] EV_DONE    = 4'd3;
  localparam logic [3:0] EV_ABANDON = 4'd4;
  localparam logic [3:0] EV_RESUME  = 4'd5;
  localparam logic [3:0] EV_SKIPBRK = 4'd6;
  localparam logic [3:0] EV_SUBMIT  = 4'd7;
  localparam logic [3:0] EV_SKIP    = 4'd8;
  localparam logic [3:0] EV_RESET   = 4'd9;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EVERY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REFLECT = 3'd4;

  // field widths
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned EVERY_W = 8;
  localparam int unsigned STAMP_W = 32;

  // register reset values
  localparam logic [LEN_W-1:0]   FOCUS_RST = 16'd1500;
  localparam logic [LEN_W-1:0]   SHORT_RST = 16'd300;
  localparam logic [LEN_W-1:0]   LONG_RST  = 16'd900;
  localparam logic [EVERY_W-1:0] EVERY_RST = 8'd4;

  // controller states
  typedef enum logic [1:0] {
    C_WAIT  = 2'd0,
    C_DIV   = 2'd1,
    C_APPLY = 2'd2
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic mod_start;
    logic apply;
  } fbst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_mod;
    logic mod_done;
    logic out_blocked;
  } fbst_sts_t;

endpackage

// ----- sv/focus_break_session_timer.sv -----
// focus/break session timer, top level
// joins fbst_ctrl and fbst_datapath; uses fbst_pkg
//
// usage:
//   input channel (in_valid, in_stall, func, now): one event word per item,
//   taken at an edge with in_valid high and in_stall low
//   output channel (out_valid, out_stall, *_out): one result word per event,
//   the whole timer state after the event; taken when out_stall is low
//   configuration (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is
//   always high; indexes 0..4 select the lengths, the long-break interval and
//   the reflection enable; other indexes are ignored
// timing:
//   an event is latched, then its update is committed in the apply state; done
//   while focusing with a nonzero session count and interval first waits in the
//   divide state for the bit-serial remainder unit (one session-count bit per cycle)
//   a new event is taken only while the controller waits and no result word is
//   held stalled, so no event is taken before the previous one is committed
// reset: synchronous; registers return to their defaults, phase idle
// stall: a held result keeps in_stall high; the word stays unchanged
module focus_break_session_timer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [3:0]                        func,
  input  logic [fbst_pkg::STAMP_W-1:0]      now,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        phase_out,
  output logic [fbst_pkg::LEN_W-1:0]        remaining_out,
  output logic [fbst_pkg::CNT_W-1:0]        session_out,
  output logic [fbst_pkg::STAMP_W-1:0]      started_out,
  output logic [fbst_pkg::STAMP_W-1:0]      paused_out,
  output logic                              long_kind_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fbst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbst_pkg::LEN_W-1:0]        cfg_data
);
  import fbst_pkg::*;

  fbst_cmd_t cmd;
  fbst_sts_t sts;

  // register writes never wait
  assign cfg_ready = 1'b1;

  fbst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbst_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .func          (func),
    .now           (now),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .phase_out     (phase_out),
    .remaining_out (remaining_out),
    .session_out   (session_out),
    .started_out   (started_out),
    .paused_out    (paused_out),
    .long_kind_out (long_kind_out)
  );

  // checks
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid) else $error("result before its event");

endmodule

// ----- sv/fbst_modulo.sv -----
// serial remainder unit: session count modulo the long-break interval
// one dividend bit per cycle, restoring; uses fbst_pkg
module fbst_modulo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fbst_pkg::CNT_W-1:0]    dividend,
  input  logic [fbst_pkg::EVERY_W-1:0]  divisor,
  output logic                          done,
  output logic                          rem_zero
);
  import fbst_pkg::*;

  localparam int unsigned STEP_W = $clog2(CNT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CNT_W - 1);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   dvd;
  logic [EVERY_W-1:0] dsr;
  logic [EVERY_W-1:0] rem;
  logic [EVERY_W:0]   trial;
  logic [EVERY_W:0]   diff;

  // one restoring step
  assign trial = {rem, dvd[CNT_W-1]};
  assign diff  = trial - {1'b0, dsr};

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) busy <= 1'b0;
      end
    end
  end

  // operand and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[CNT_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) rem <= diff[EVERY_W-1:0];
      else                      rem <= trial[EVERY_W-1:0];
    end
  end

  assign rem_zero = (rem == '0);

  // checks
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("modulo did not start");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (busy && dsr != '0) |=> (rem < dsr)) else $error("remainder not below divisor");

endmodule

// ----- sv/fbst_datapath.sv -----
// datapath: configuration registers, timer state, event latch and result flag
// uses fbst_pkg and fbst_modulo
module fbst_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  fbst_pkg::fbst_cmd_t               cmd,
  output fbst_pkg::fbst_sts_t               sts,
  input  logic [3:0]                        func,
  input  logic [fbst_pkg::STAMP_W-1:0]      now,
  input  logic                              cfg_valid,
  input  logic [fbst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbst_pkg::LEN_W-1:0]        cfg_data,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [3:0]                        phase_out,
  output logic [fbst_pkg::LEN_W-1:0]        remaining_out,
  output logic [fbst_pkg::CNT_W-1:0]        session_out,
  output logic [fbst_pkg::STAMP_W-1:0]      started_out,
  output logic [fbst_pkg::STAMP_W-1:0]      paused_out,
  output logic                              long_kind_out
);
  import fbst_pkg::*;

  logic [LEN_W-1:0]   focus_length;
  logic [LEN_W-1:0]   short_break_length;
  logic [LEN_W-1:0]   long_break_length;
  logic [EVERY_W-1:0] sessions_per_long_break;
  logic               reflection_on;

  phase_t             phase, phase_next;
  logic [LEN_W-1:0]   remaining, remaining_next;
  logic [CNT_W-1:0]   session_count, session_count_next;
  logic [STAMP_W-1:0] start_stamp, start_stamp_next;
  logic [STAMP_W-1:0] pause_stamp, pause_stamp_next;
  logic               break_is_long, break_is_long_next;

  logic [3:0]         ev;
  logic [STAMP_W-1:0] ev_now;
  logic               long_chk;
  logic               mod_done;
  logic               rem_zero;
  logic               long_due;
  logic [CNT_W-1:0]   session_inc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      focus_length            <= FOCUS_RST;
      short_break_length      <= SHORT_RST;
      long_break_length       <= LONG_RST;
      sessions_per_long_break <= EVERY_RST;
      reflection_on           <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FOCUS:   focus_length            <= cfg_data;
        CFG_SHORT:   short_break_length      <= cfg_data;
        CFG_LONG:    long_break_length       <= cfg_data;
        CFG_EVERY:   sessions_per_long_break <= cfg_data[EVERY_W-1:0];
        CFG_REFLECT: reflection_on           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the long-break check needs the remainder unit only for done in focus
  assign sts.need_mod = (phase == PH_FOCUS) && (func == EV_DONE)
                        && (session_count != '0) && (sessions_per_long_break != '0);

  // event latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ev       <= func;
      ev_now   <= now;
      long_chk <= sts.need_mod;
    end
  end

  fbst_modulo u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (session_count),
    .divisor  (sessions_per_long_break),
    .done     (mod_done),
    .rem_zero (rem_zero)
  );

  assign sts.mod_done = mod_done;
  assign long_due     = long_chk && rem_zero;
  assign session_inc  = (session_count == '1) ? session_count : session_count + 1'b1;

  // phase transition for the latched event
  always_comb begin
    phase_next         = phase;
    remaining_next     = remaining;
    session_count_next = session_count;
    start_stamp_next   = start_stamp;
    pause_stamp_next   = pause_stamp;
    break_is_long_next = break_is_long;
    unique case (phase)
      PH_IDLE: begin
        if (ev == EV_START) begin
          session_count_next = CNT_W'(1);
          phase_next         = PH_FOCUS;
          remaining_next     = focus_length;
          start_stamp_next   = ev_now;
          pause_stamp_next   = '0;
          break_is_long_next = 1'b0;
        end
      end
      PH_FOCUS: begin
        if (ev == EV_PAUSE) begin
          phase_next         = PH_PAUSED;
          start_stamp_next   = '0;
          pause_stamp_next   = ev_now;
          break_is_long_next = 1'b0;
        end else if (ev == EV_TICK) begin
          if (remaining != '0) remaining_next = remaining - 1'b1;
        end else if (ev == EV_DONE) begin
          phase_next         = long_due ? PH_LONG : PH_SHORT;
          remaining_next     = long_due ? long_break_length : short_break_length;
          start_stamp_next   = ev_now;
          pause_stamp_next   = '0;
          break_is_long_next = 1'b0;
        end else if (ev == EV_ABANDON) begin
          phase_next         = PH_ABANDON;
          remaining_next     = '0;
          start_stamp_next   = ev_now;
          pause_stamp_next   = '0;
          break_is_long_next = 1'b0;
        end
      end
      PH_PAUSED: begin
        if (ev == EV_RESUME) begin
          phase_next         = PH_FOCUS;
          start_stamp_next   = ev_now;
          pause_stamp_next   = '0;
          break_is_long_next = 1'b0;
        end else if (ev == EV_ABANDON) begin
          phase_next         = PH_ABANDON;
          remaining_next     = '0;
          start_stamp_next   = ev_now;
          pause_stamp_next   = '0;
          break_is_long_next = 1'b0;
        end
      end
      PH_SHORT, PH_LONG: begin
        if (ev == EV_PAUSE) begin
          phase_next         = PH_BPAUSED;
          start_stamp_next   = '0;
          pause_stamp_next   = ev_now;
          break_is_long_next = (phase == PH_LONG);
        end else if (ev == EV_TICK) begin
          if (remaining != '0) remaining_next = remaining - 1'b1;
        end else if (ev == EV_DONE || ev == EV_SKIPBRK) begin
          pause_stamp_next   = '0;
          break_is_long_next = 1'b0;
          if (reflection_on) begin
            phase_next       = PH_REFLECT;
            remaining_next   = '0;
            start_stamp_next = '0;
          end else begin
            session_count_next = session_inc;
            phase_next         = PH_FOCUS;
            remaining_next     = focus_length;
            start_stamp_next   = ev_now;
          end
        end else if (ev == EV_ABANDON) begin
          phase_next         = PH_ABANDON;
          remaining_next     = '0;
          start_stamp_next   = ev_now;
          pause_stamp_next   = '0;
          break_is_long_next = 1'b0;
        end
      end
      PH_BPAUSED: begin
        if (ev == EV_RESUME) begin
          phase_next       = break_is_long ? PH_LONG : PH_SHORT;
          start_stamp_next = ev_now;
          pause_stamp_next = '0;
        end else if (ev == EV_SKIPBRK) begin
          pause_stamp_next   = '0;
          break_is_long_next = 1'b0;
          if (reflection_on) begin
            phase_next       = PH_REFLECT;
            remaining_next   = '0;
            start_stamp_next = '0;
          end else begin
            session_count_next = session_inc;
            phase_next         = PH_FOCUS;
            remaining_next     = focus_length;
            start_stamp_next   = ev_now;
          end
        end else if (ev == EV_ABANDON) begin
          phase_next         = PH_ABANDON;
          remaining_next     = '0;
          start_stamp_next   = ev_now;
          pause_stamp_next   = '0;
          break_is_long_next = 1'b0;
        end
      end
      PH_REFLECT: begin
        if (ev == EV_SUBMIT || ev == EV_SKIP) begin
          phase_next         = PH_COMPLETE;
          remaining_next     = '0;
          start_stamp_next   = '0;
          pause_stamp_next   = '0;
          break_is_long_next = 1'b0;
        end
      end
      PH_COMPLETE, PH_ABANDON: begin
        if (ev == EV_RESET) begin
          session_count_next = '0;
          phase_next         = PH_IDLE;
          remaining_next     = focus_length;
          start_stamp_next   = '0;
          pause_stamp_next   = '0;
          break_is_long_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // timer state, which also stands as the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      remaining     <= FOCUS_RST;
      session_count <= '0;
      start_stamp   <= '0;
      pause_stamp   <= '0;
      break_is_long <= 1'b0;
    end else if (cmd.apply) begin
      phase         <= phase_next;
      remaining     <= remaining_next;
      session_count <= session_count_next;
      start_stamp   <= start_stamp_next;
      pause_stamp   <= pause_stamp_next;
      break_is_long <= break_is_long_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_blocked = out_valid && out_stall;

  assign phase_out     = phase;
  assign remaining_out = remaining;
  assign session_out   = session_count;
  assign started_out   = start_stamp;
  assign paused_out    = pause_stamp;
  assign long_kind_out = break_is_long;

  // checks
  a_apply_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> out_valid) else $error("result not shown after update");
  a_apply_free: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> !out_valid) else $error("state updated under a pending result");

endmodule

// ----- sv/fbst_ctrl.sv -----
// controller: accepts an event, runs the long-break check when needed, commits the update
// uses fbst_pkg
module fbst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fbst_pkg::fbst_sts_t  sts,
  output fbst_pkg::fbst_cmd_t  cmd
);
  import fbst_pkg::*;

  ctrl_state_t state, state_next;
  logic        accept;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= C_WAIT;
    else     state <= state_next;
  end

  // a new event only in the wait state, once the previous result word is taken or leaving
  assign in_stall = (state != C_WAIT) || sts.out_blocked;
  assign accept   = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd.latch     = 1'b0;
    cmd.mod_start = 1'b0;
    cmd.apply     = 1'b0;
    unique case (state)
      C_WAIT: begin
        if (accept) begin
          cmd.latch = 1'b1;
          if (sts.need_mod) begin
            cmd.mod_start = 1'b1;
            state_next    = C_DIV;
          end else begin
            state_next = C_APPLY;
          end
        end
      end
      C_DIV: begin
        if (sts.mod_done) state_next = C_APPLY;
      end
      C_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = C_WAIT;
      end
      default: state_next = C_WAIT;
    endcase
  end

  // checks
  a_apply_once: assert property (@(posedge clk) disable iff (rst)
    state == C_APPLY |=> state == C_WAIT) else $error("update not single cycle");

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for focus_break_session_timer
// drives event words, predicts the timer state after each one and compares result words
// depends on fbst_pkg and the focus_break_session_timer rtl
module tb_top;
  import fbst_pkg::*;

  localparam int FUNC_MAX    = 15;
  localparam int CFG_IDX_MAX = (1 << CFG_IDX_W) - 1;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_SETTING = 100;
  localparam int SETTINGS_COUNT    = 8;

  // timer state as reported on one result word
  typedef struct packed {
    phase_t             ph;
    logic [LEN_W-1:0]   rem;
    logic [CNT_W-1:0]   ses;
    logic [STAMP_W-1:0] started;
    logic [STAMP_W-1:0] paused;
    logic               long_kind;
  } timer_state_t;

  typedef struct packed {
    logic [3:0]         code;
    logic [STAMP_W-1:0] stamp;
  } event_word_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [3:0]           func = '0;
  logic [STAMP_W-1:0]   now = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [3:0]           phase_out;
  logic [LEN_W-1:0]     remaining_out;
  logic [CNT_W-1:0]     session_out;
  logic [STAMP_W-1:0]   started_out;
  logic [STAMP_W-1:0]   paused_out;
  logic                 long_kind_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;

  // shadow copy of the configuration registers
  logic [LEN_W-1:0]   cfg_focus_len;
  logic [LEN_W-1:0]   cfg_short_len;
  logic [LEN_W-1:0]   cfg_long_len;
  logic [EVERY_W-1:0] cfg_every;
  logic               cfg_reflect;

  timer_state_t model_st;       // state after the last accepted word
  timer_state_t plan_st;        // state after the last queued word
  event_word_t  pending_events[$];
  timer_state_t due_states[$];

  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           hold_left = 0;
  int           span_left = 0;
  logic         hold_armed = 1'b0;
  logic         hold_done = 1'b0;
  stall_mode_t  stall_mode = STALL_NONE;

  focus_break_session_timer u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .now           (now),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .phase_out     (phase_out),
    .remaining_out (remaining_out),
    .session_out   (session_out),
    .started_out   (started_out),
    .paused_out    (paused_out),
    .long_kind_out (long_kind_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // next timer state for one event, using the shadow configuration
  function automatic timer_state_t next_timer_state(timer_state_t s, logic [3:0] ev,
                                                    logic [STAMP_W-1:0] t);
    timer_state_t     n;
    logic             long_due;
    logic [CNT_W-1:0] ses_next;
    logic [LEN_W-1:0] rem_down;
    timer_state_t     break_end;
    timer_state_t     abandoned;
    n         = s;
    long_due  = (s.ses != 0) && (cfg_every != 0) && ((s.ses % cfg_every) == 0);
    ses_next  = (s.ses == '1) ? s.ses : s.ses + 1'b1;
    rem_down  = (s.rem != 0) ? s.rem - 1'b1 : s.rem;
    abandoned = '{PH_ABANDON, '0, s.ses, t, '0, 1'b0};
    // end of a break: reflection if enabled, else straight into the next focus session
    if (cfg_reflect)
      break_end = '{PH_REFLECT, '0, s.ses, '0, '0, 1'b0};
    else
      break_end = '{PH_FOCUS, cfg_focus_len, ses_next, t, '0, 1'b0};
    case (s.ph)
      PH_IDLE: begin
        if (ev == EV_START) n = '{PH_FOCUS, cfg_focus_len, 16'd1, t, '0, 1'b0};
      end
      PH_FOCUS: begin
        if (ev == EV_PAUSE) n = '{PH_PAUSED, s.rem, s.ses, '0, t, 1'b0};
        else if (ev == EV_TICK) n.rem = rem_down;
        else if (ev == EV_DONE && long_due) n = '{PH_LONG, cfg_long_len, s.ses, t, '0, 1'b0};
        else if (ev == EV_DONE) n = '{PH_SHORT, cfg_short_len, s.ses, t, '0, 1'b0};
        else if (ev == EV_ABANDON) n = abandoned;
      end
      PH_PAUSED: begin
        if (ev == EV_RESUME) n = '{PH_FOCUS, s.rem, s.ses, t, '0, 1'b0};
        else if (ev == EV_ABANDON) n = abandoned;
      end
      PH_SHORT, PH_LONG: begin
        if (ev == EV_PAUSE) n = '{PH_BPAUSED, s.rem, s.ses, '0, t, s.ph == PH_LONG};
        else if (ev == EV_TICK) n.rem = rem_down;
        else if (ev == EV_DONE || ev == EV_SKIPBRK) n = break_end;
        else if (ev == EV_ABANDON) n = abandoned;
      end
      PH_BPAUSED: begin
        if (ev == EV_RESUME && s.long_kind) n = '{PH_LONG, s.rem, s.ses, t, '0, 1'b1};
        else if (ev == EV_RESUME) n = '{PH_SHORT, s.rem, s.ses, t, '0, 1'b0};
        else if (ev == EV_SKIPBRK) n = break_end;
        else if (ev == EV_ABANDON) n = abandoned;
      end
      PH_REFLECT: begin
        if (ev == EV_SUBMIT || ev == EV_SKIP) n = '{PH_COMPLETE, '0, s.ses, '0, '0, 1'b0};
      end
      PH_COMPLETE, PH_ABANDON: begin
        if (ev == EV_RESET) n = '{PH_IDLE, cfg_focus_len, '0, '0, '0, 1'b0};
      end
      default: n = s;
    endcase
    return n;
  endfunction

  // driver: bursts of words with random gaps, payload held while stalled
  always @(posedge clk) begin
    event_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        model_st = next_timer_state(model_st, func, now);
        due_states.push_back(model_st);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          w = pending_events.pop_front();
          func     <= w.code;
          now      <= w.stamp;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(20, 40);
              default: gap_left = $urandom_range(1, 8);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: changing pattern, plus one long hold-off once armed
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_armed && !hold_done && out_valid) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      out_stall <= 1'b1;
    end else begin
      if (span_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        span_left  = $urandom_range(20, 150);
      end else begin
        span_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // monitor: each result word against the oldest predicted state
  always @(posedge clk) begin
    timer_state_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_states.size() == 0) begin
        $display("%0t: result word with nothing expected, phase %0h", $time, phase_out);
        mismatches++;
      end else begin
        want = due_states.pop_front();
        check_field("phase", 32'(want.ph), 32'(phase_out));
        check_field("remaining", 32'(want.rem), 32'(remaining_out));
        check_field("session", 32'(want.ses), 32'(session_out));
        check_field("started", want.started, started_out);
        check_field("paused", want.paused, paused_out);
        check_field("long_kind", 32'(want.long_kind), 32'(long_kind_out));
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one register write; leaves cfg_valid high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FOCUS:   cfg_focus_len = val;
      CFG_SHORT:   cfg_short_len = val;
      CFG_LONG:    cfg_long_len  = val;
      CFG_EVERY:   cfg_every     = val[EVERY_W-1:0];
      CFG_REFLECT: cfg_reflect   = val[0];
      default: ;
    endcase
  endtask

  // full register set, junk in the unused upper bits, plus a write to an unused index
  task automatic apply_setting(input logic [LEN_W-1:0] f, input logic [LEN_W-1:0] s,
                               input logic [LEN_W-1:0] l, input logic [EVERY_W-1:0] e,
                               input logic r);
    @(posedge clk);
    write_reg(CFG_FOCUS, f);
    write_reg(CFG_SHORT, s);
    write_reg(CFG_LONG, l);
    write_reg(CFG_EVERY, {8'($urandom), e});
    write_reg(CFG_REFLECT, {15'($urandom), r});
    write_reg(CFG_IDX_W'($urandom_range(int'(CFG_REFLECT) + 1, CFG_IDX_MAX)), 16'($urandom));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_event(input logic [3:0] code, input logic [STAMP_W-1:0] stamp);
    pending_events.push_back('{code, stamp});
    plan_st = next_timer_state(plan_st, code, stamp);
  endtask

  // wait until every word is sent and every result has come back
  task automatic drain();
    @(negedge clk);
    while (pending_events.size() != 0 || due_states.size() != 0 || in_valid)
      @(negedge clk);
  endtask

  // mostly events that make progress in the given phase, some noise
  function automatic logic [3:0] pick_event(phase_t p);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 4'($urandom_range(int'(EV_RESET) + 1, FUNC_MAX));
    if (r < 15) return 4'($urandom_range(0, int'(EV_RESET)));
    r = $urandom_range(0, 99);
    case (p)
      PH_IDLE:   return EV_START;
      PH_FOCUS:  return (r < 45) ? EV_TICK : (r < 80) ? EV_DONE :
                        (r < 95) ? EV_PAUSE : EV_ABANDON;
      PH_PAUSED: return (r < 90) ? EV_RESUME : EV_ABANDON;
      PH_SHORT, PH_LONG:
                 return (r < 35) ? EV_TICK : (r < 60) ? EV_DONE : (r < 80) ? EV_SKIPBRK :
                        (r < 95) ? EV_PAUSE : EV_ABANDON;
      PH_BPAUSED: return (r < 60) ? EV_RESUME : (r < 95) ? EV_SKIPBRK : EV_ABANDON;
      PH_REFLECT: return (r < 50) ? EV_SUBMIT : EV_SKIP;
      default:   return EV_RESET;
    endcase
  endfunction

  function automatic logic [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      5: return 16'($urandom);
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [EVERY_W-1:0] pick_every();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 8'd1;
      2: return '1;
      default: return 8'($urandom_range(2, 5));
    endcase
  endfunction

  // stimulus sequence
  initial begin
    cfg_focus_len = FOCUS_RST;
    cfg_short_len = SHORT_RST;
    cfg_long_len  = LONG_RST;
    cfg_every     = EVERY_RST;
    cfg_reflect   = 1'b0;
    model_st      = '{PH_IDLE, FOCUS_RST, '0, '0, '0, 1'b0};
    plan_st       = model_st;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // one-tick lengths so countdowns hit zero, long break after every session
    apply_setting(16'd1, 16'd1, 16'd1, 8'd1, 1'b0);
    queue_event(EV_RESET, 32'h1);
    queue_event(4'(FUNC_MAX), 32'h2);
    queue_event(EV_START, '1);
    queue_event(EV_TICK, 32'h3);
    queue_event(EV_TICK, 32'h4);
    queue_event(EV_PAUSE, '0);
    queue_event(EV_RESUME, 32'h8000_0001);
    queue_event(EV_DONE, 32'h5A5A_A5A5);
    queue_event(EV_PAUSE, 32'hA5A5_5A5A);
    queue_event(EV_RESUME, 32'h0F0F_F0F0);
    queue_event(EV_TICK, 32'h5);
    queue_event(EV_TICK, 32'h6);
    queue_event(EV_PAUSE, 32'h7);
    queue_event(EV_SKIPBRK, 32'h7FFF_FFFE);
    queue_event(EV_ABANDON, 32'hFFFF_0000);
    queue_event(EV_START, 32'h8);
    queue_event(EV_RESET, 32'h9);
    drain();

    // reflection path, long breaks off
    apply_setting(16'd3, 16'd2, 16'd4, 8'd0, 1'b1);
    queue_event(EV_START, 32'hA);
    queue_event(EV_DONE, 32'hB);
    queue_event(EV_PAUSE, 32'hC);
    queue_event(EV_SKIPBRK, 32'hD);
    queue_event(EV_SUBMIT, 32'hE);
    queue_event(EV_RESET, 32'hF);
    queue_event(EV_START, 32'h10);
    queue_event(EV_DONE, 32'h11);
    queue_event(EV_DONE, 32'h12);
    queue_event(EV_SKIP, 32'h13);
    drain();

    // random sessions over several settings, extremes first
    for (int k = 0; k < SETTINGS_COUNT; k++) begin
      case (k)
        0: apply_setting('1, '1, '1, '1, 1'b0);
        1: apply_setting('0, '0, '0, '0, 1'b1);
        2: apply_setting(16'd2, 16'd1, 16'd2, 8'd1, 1'b0);
        default: apply_setting(pick_len(), pick_len(), pick_len(), pick_every(),
                               1'($urandom_range(0, 1)));
      endcase
      if (k == 2) hold_armed = 1'b1;
      for (int i = 0; i < ITEMS_PER_SETTING; i++)
        queue_event(pick_event(plan_st.ph), pick_stamp());
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
